// ===== rtl/mbg_pkg.sv =====
// Shared types and constants of the maze backtracker generator.
// Holds the controller/datapath command and status structs and code enums.
// No dependencies.
package mbg_pkg;

    localparam int unsigned DEF_MAX_COLS = 32;
    localparam int unsigned DEF_MAX_ROWS = 32;

    localparam int CFG_W     = 6;   // widest configuration register
    localparam int DIM_W     = 6;   // grid width and height
    localparam int POS_W     = 5;   // start row/col and reported row/col
    localparam int CNT_W     = 12;  // cell counts, up to 63 * 63
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;

    localparam logic [DIM_W-1:0] RST_GRID_WIDTH  = 6'd20;
    localparam logic [DIM_W-1:0] RST_GRID_HEIGHT = 6'd15;
    localparam logic [POS_W-1:0] RST_START_ROW   = 5'd0;
    localparam logic [POS_W-1:0] RST_START_COL   = 5'd0;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_DRAW  = 1'b1;

    typedef enum logic [1:0] {
        REG_GRID_WIDTH,
        REG_GRID_HEIGHT,
        REG_START_ROW,
        REG_START_COL
    } t_cfg_reg;

    typedef enum logic [1:0] {
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    // Which row of the visited map to read
    typedef enum logic [1:0] {
        RD_NB,
        RD_CUR,
        RD_UP,
        RD_DN
    } t_rd_sel;

    typedef struct packed {
        logic    load_in;
        logic    start;
        logic    clr_wr;
        t_rd_sel rd_sel;
        logic    carve;
        logic    lat_lr;
        logic    lat_up;
        logic    pop;
        logic    pop_ld;
        logic    res_load;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic finished;
        logic nb_ok;
        logic nb_fresh;
        logic last_carve;
        logic fresh_any;
        logic depth_zero;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/mbg_ctrl.sv =====
// Sequencer of the maze backtracker generator.
// Drives mbg_datapath through t_cmd and reacts to t_sts; uses mbg_pkg.
module mbg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  mbg_pkg::t_sts i_sts,
    output mbg_pkg::t_cmd o_cmd
);
    import mbg_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_CLEAR,
        S_TEST,
        S_CK_CUR,
        S_CK_UP,
        S_CK_DN,
        S_CK_EVAL,
        S_POPLD,
        S_RES
    } t_state;

    t_state r_state, n_state;
    logic   r_tready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = RD_CUR;
        o_cmd.load_in  = i_s_axis_tvalid && r_tready;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load_in) n_state = S_DISP;
            end
            S_DISP: begin
                if (i_sts.mode == MODE_START) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CLEAR;
                end else if (i_sts.finished || !i_sts.nb_ok) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.rd_sel = RD_NB;
                    n_state      = S_TEST;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_RES;
            end
            S_TEST: begin
                if (i_sts.nb_fresh) begin
                    o_cmd.carve = 1'b1;
                    n_state     = i_sts.last_carve ? S_RES : S_CK_CUR;
                end else begin
                    n_state = S_RES;
                end
            end
            S_CK_CUR: begin
                o_cmd.rd_sel = RD_CUR;
                n_state      = S_CK_UP;
            end
            S_CK_UP: begin
                o_cmd.lat_lr = 1'b1;
                o_cmd.rd_sel = RD_UP;
                n_state      = S_CK_DN;
            end
            S_CK_DN: begin
                o_cmd.lat_up = 1'b1;
                o_cmd.rd_sel = RD_DN;
                n_state      = S_CK_EVAL;
            end
            S_CK_EVAL: begin
                if (i_sts.fresh_any || i_sts.depth_zero) begin
                    n_state = S_RES;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_POPLD;
                end
            end
            S_POPLD: begin
                o_cmd.pop_ld = 1'b1;
                n_state      = S_CK_CUR;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tready <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_tready <= (n_state == S_IDLE);
        end
    end

    assign o_s_axis_tready = r_tready;

endmodule

// ===== rtl/mbg_datapath.sv =====
// Datapath of the maze backtracker generator: walk state, visited map,
// path stack and output register. Commanded by mbg_ctrl; uses mbg_pkg.
module mbg_datapath #(
    parameter int unsigned MAX_COLS = mbg_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = mbg_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbg_pkg::t_cmd                 i_cmd,
    output mbg_pkg::t_sts                 o_sts,
    input  logic                          i_mode,
    input  mbg_pkg::t_dir                 i_dir,
    input  logic [mbg_pkg::DIM_W-1:0]     i_grid_width,
    input  logic [mbg_pkg::DIM_W-1:0]     i_grid_height,
    input  logic [mbg_pkg::POS_W-1:0]     i_start_row,
    input  logic [mbg_pkg::POS_W-1:0]     i_start_col,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic                          o_out_carved,
    output logic [mbg_pkg::POS_W-1:0]     o_out_row,
    output logic [mbg_pkg::POS_W-1:0]     o_out_col,
    output mbg_pkg::t_dir                 o_out_wall,
    output logic                          o_out_done
);
    import mbg_pkg::*;

    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int SW    = $clog2(CELLS);
    localparam int DW    = $clog2(CELLS + 1);
    localparam logic [MAX_COLS-1:0] ONE_C   = MAX_COLS'(1);
    localparam logic [RW-1:0]       LAST_RW = RW'(MAX_ROWS - 1);

    // walk state
    logic [DIM_W-1:0] r_used_w, r_used_h;
    logic [RW-1:0]    r_cur_r;
    logic [CW-1:0]    r_cur_c;
    logic [DW-1:0]    r_depth;
    logic [CNT_W-1:0] r_visited, r_cells;
    logic             r_finished;
    logic [RW-1:0]    r_clr_cnt;
    logic             r_out_valid;

    // item and result holding
    logic             r_mode;
    t_dir             r_dir;
    logic             r_res_carved;
    logic [POS_W-1:0] r_res_row, r_res_col;
    t_dir             r_res_wall;
    logic             r_fr_l, r_fr_r, r_fr_u;
    logic             r_out_carved, r_out_done;
    logic [POS_W-1:0] r_out_row, r_out_col;
    t_dir             r_out_wall;

    // memories
    logic [MAX_COLS-1:0] r_vmap [MAX_ROWS];
    logic [MAX_COLS-1:0] r_vrow;
    logic [RW+CW-1:0]    r_stack [CELLS];
    logic [RW+CW-1:0]    r_st_rd;

    logic [DIM_W-1:0]    cw_clamp, ch_clamp;
    logic [RW-1:0]       sr_clamp;
    logic [CW-1:0]       sc_clamp;
    logic [RW-1:0]       nb_r;
    logic [CW-1:0]       nb_c;
    logic                nb_ok;
    logic                left_ok, right_ok, up_ok, down_ok;
    logic                down_fresh;
    logic                vm_we;
    logic [RW-1:0]       vm_waddr, vm_raddr;
    logic [MAX_COLS-1:0] vm_wdata;
    logic [DW-1:0]       depth_m1;
    logic [CNT_W-1:0]    visited_p1;

    // Clamp the configured grid and start cell
    always_comb begin
        if (i_grid_width == '0)                     cw_clamp = DIM_W'(1);
        else if (9'(i_grid_width) > 9'(MAX_COLS))   cw_clamp = DIM_W'(MAX_COLS);
        else                                        cw_clamp = i_grid_width;
        if (i_grid_height == '0)                    ch_clamp = DIM_W'(1);
        else if (9'(i_grid_height) > 9'(MAX_ROWS))  ch_clamp = DIM_W'(MAX_ROWS);
        else                                        ch_clamp = i_grid_height;
        if (DIM_W'(i_start_row) < ch_clamp) sr_clamp = RW'(i_start_row);
        else                                sr_clamp = RW'(ch_clamp - 1'b1);
        if (DIM_W'(i_start_col) < cw_clamp) sc_clamp = CW'(i_start_col);
        else                                sc_clamp = CW'(cw_clamp - 1'b1);
    end

    assign left_ok  = (r_cur_c != '0);
    assign right_ok = (9'(r_cur_c) + 9'd1) < 9'(r_used_w);
    assign up_ok    = (r_cur_r != '0);
    assign down_ok  = (9'(r_cur_r) + 9'd1) < 9'(r_used_h);

    // Neighbor toward the drawn direction
    always_comb begin
        nb_r  = r_cur_r;
        nb_c  = r_cur_c;
        nb_ok = 1'b0;
        case (r_dir)
            DIR_LEFT:  begin nb_ok = left_ok;  nb_c = r_cur_c - 1'b1; end
            DIR_RIGHT: begin nb_ok = right_ok; nb_c = r_cur_c + 1'b1; end
            DIR_UP:    begin nb_ok = up_ok;    nb_r = r_cur_r - 1'b1; end
            DIR_DOWN:  begin nb_ok = down_ok;  nb_r = r_cur_r + 1'b1; end
            default:   nb_ok = 1'b0;
        endcase
    end

    always_comb begin
        case (i_cmd.rd_sel)
            RD_NB:   vm_raddr = nb_r;
            RD_CUR:  vm_raddr = r_cur_r;
            RD_UP:   vm_raddr = r_cur_r - 1'b1;
            RD_DN:   vm_raddr = r_cur_r + 1'b1;
            default: vm_raddr = r_cur_r;
        endcase
    end

    // Clear sweep writes whole rows; a carve sets one bit of the row just read
    assign vm_we    = i_cmd.clr_wr || i_cmd.carve;
    assign vm_waddr = i_cmd.carve ? nb_r : r_clr_cnt;
    always_comb begin
        if (i_cmd.carve)               vm_wdata = r_vrow | (ONE_C << nb_c);
        else if (r_clr_cnt == r_cur_r) vm_wdata = ONE_C << r_cur_c;
        else                           vm_wdata = '0;
    end

    assign depth_m1   = r_depth - 1'b1;
    assign visited_p1 = r_visited + 1'b1;
    assign down_fresh = down_ok && !r_vrow[r_cur_c];

    always_ff @(posedge i_clk) begin
        if (vm_we) r_vmap[vm_waddr] <= vm_wdata;
        r_vrow <= r_vmap[vm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.carve) r_stack[r_depth[SW-1:0]] <= {r_cur_r, r_cur_c};
        r_st_rd <= r_stack[depth_m1[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_w    <= DIM_W'(1);
            r_used_h    <= DIM_W'(1);
            r_cur_r     <= '0;
            r_cur_c     <= '0;
            r_depth     <= '0;
            r_visited   <= '0;
            r_cells     <= CNT_W'(1);
            r_finished  <= 1'b1;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_used_w   <= cw_clamp;
                r_used_h   <= ch_clamp;
                r_cur_r    <= sr_clamp;
                r_cur_c    <= sc_clamp;
                r_depth    <= '0;
                r_visited  <= CNT_W'(1);
                r_cells    <= CNT_W'(cw_clamp) * CNT_W'(ch_clamp);
                r_finished <= (cw_clamp == DIM_W'(1)) && (ch_clamp == DIM_W'(1));
                r_clr_cnt  <= '0;
            end
            if (i_cmd.clr_wr) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (i_cmd.carve) begin
                r_depth   <= r_depth + 1'b1;
                r_cur_r   <= nb_r;
                r_cur_c   <= nb_c;
                r_visited <= visited_p1;
                if (visited_p1 >= r_cells) r_finished <= 1'b1;
            end
            if (i_cmd.pop) r_depth <= depth_m1;
            if (i_cmd.pop_ld) begin
                r_cur_r <= r_st_rd[RW+CW-1:CW];
                r_cur_c <= r_st_rd[CW-1:0];
            end
            if (i_cmd.res_load)     r_out_valid <= 1'b1;
            else if (i_m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode       <= i_mode;
            r_dir        <= i_dir;
            r_res_carved <= 1'b0;
            r_res_row    <= '0;
            r_res_col    <= '0;
            r_res_wall   <= DIR_LEFT;
        end
        if (i_cmd.carve) begin
            r_res_carved <= 1'b1;
            r_res_row    <= POS_W'(r_cur_r);
            r_res_col    <= POS_W'(r_cur_c);
            r_res_wall   <= r_dir;
        end
        if (i_cmd.lat_lr) begin
            r_fr_l <= left_ok  && !r_vrow[r_cur_c - 1'b1];
            r_fr_r <= right_ok && !r_vrow[r_cur_c + 1'b1];
        end
        if (i_cmd.lat_up) r_fr_u <= up_ok && !r_vrow[r_cur_c];
        if (i_cmd.res_load) begin
            r_out_carved <= r_res_carved;
            r_out_row    <= r_res_row;
            r_out_col    <= r_res_col;
            r_out_wall   <= r_res_wall;
            r_out_done   <= r_finished;
        end
    end

    assign o_sts.mode       = r_mode;
    assign o_sts.finished   = r_finished;
    assign o_sts.nb_ok      = nb_ok;
    assign o_sts.nb_fresh   = !r_vrow[nb_c];
    assign o_sts.last_carve = (visited_p1 >= r_cells);
    assign o_sts.fresh_any  = r_fr_l || r_fr_r || r_fr_u || down_fresh;
    assign o_sts.depth_zero = (r_depth == '0);
    assign o_sts.clr_last   = (r_clr_cnt == LAST_RW);
    assign o_sts.out_free   = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_out_carved    = r_out_carved;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_out_wall      = r_out_wall;
    assign o_out_done      = r_out_done;

`ifndef SYNTH
    a_depth_le_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= 32'(r_visited))
        else $error("path stack deeper than visited cell count");

    a_visited_le_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visited <= r_cells)
        else $error("visited cell count exceeds grid size");

    a_carve_only_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve |-> (!r_finished && nb_ok))
        else $error("carve issued on finished maze or off-grid neighbor");

    a_cur_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (9'(r_cur_r) < 9'(r_used_h)) && (9'(r_cur_c) < 9'(r_used_w)))
        else $error("current cell outside the grid in use");
`endif

endmodule

// ===== rtl/maze_backtracker_generator_top.sv =====
// A start word sweeps the visited map, one row cleared per cycle, before its result; a draw
// that carves then runs a dead-end test and pops one cell per failed test to backtrack.
// One item at a time; a carving draw is bounded by the single read port of the visited map
// (three row reads per dead-end test).
// Reset (synchronous, active low): idle, maze marked finished on a 1x1 grid, config at
// defaults; the visited map needs no clearing pass since every start sweeps it.
// Top level: configuration registers, stream ports, mbg_ctrl and mbg_datapath; uses mbg_pkg.
module maze_backtracker_generator_top #(
    parameter int unsigned MAX_COLS = mbg_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = mbg_pkg::DEF_MAX_ROWS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [mbg_pkg::S_DATA_W-1:0]   i_s_axis_tdata,  // [1:0] direction
    input  logic [0:0]                     i_s_axis_tuser,  // [0] mode
    // result stream
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // [4:0] cell_row, [9:5] cell_col, [11:10] wall, [12] done_res
    output logic [mbg_pkg::M_DATA_W-1:0]   o_m_axis_tdata,
    output logic [0:0]                     o_m_axis_tuser,  // [0] carved
    // configuration write port
    input  logic                           i_cfg_wr_en,
    input  logic [1:0]                     i_cfg_index,
    input  logic [mbg_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import mbg_pkg::*;

    logic [DIM_W-1:0] r_grid_width, r_grid_height;
    logic [POS_W-1:0] r_start_row, r_start_col;

    t_cmd             cmd;
    t_sts             sts;
    logic             out_carved, out_done;
    logic [POS_W-1:0] out_row, out_col;
    t_dir             out_wall;

    // Hold configuration; it takes effect at the next start word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_start_row   <= RST_START_ROW;
            r_start_col   <= RST_START_COL;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_wdata;
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_wdata;
                REG_START_ROW:   r_start_row   <= i_cfg_wdata[POS_W-1:0];
                REG_START_COL:   r_start_col   <= i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence each word: start sweep, neighbor test, carve, dead-end test, pop
    mbg_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    mbg_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_s_axis_tuser[0]),
        .i_dir           (t_dir'(i_s_axis_tdata[1:0])),
        .i_grid_width    (r_grid_width),
        .i_grid_height   (r_grid_height),
        .i_start_row     (r_start_row),
        .i_start_col     (r_start_col),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_out_carved    (out_carved),
        .o_out_row       (out_row),
        .o_out_col       (out_col),
        .o_out_wall      (out_wall),
        .o_out_done      (out_done)
    );

    // Pack the result word, first field in the lowest bits
    assign o_m_axis_tdata = {3'b000, out_done, out_wall, out_col, out_row};
    assign o_m_axis_tuser = out_carved;

endmodule
